// File: sv/crat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crat_pkg
// shared constants and types of the adaptive catmull-rom tessellator
// ----------------------------------------------------------------------------
package crat_pkg;

   localparam int MAX_DEPTH_DEFAULT   = 6;
   localparam int COORD_WIDTH_DEFAULT = 16;

   localparam int CSR_WIDTH         = 34;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int DEPTH_LIMIT_WIDTH = 3;
   localparam int THR_FRAC          = 28;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [CSR_WIDTH-1:0]         MAX_LEN_SQ_RESET  = 34'd2684355;
   localparam logic [DEPTH_LIMIT_WIDTH-1:0] DEPTH_LIMIT_RESET = 3'd6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_LEN_SQ  = 1'b0,
      CSR_DEPTH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_CHORD  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_EMIT   = 5'b10000
   } back_state_type;

endpackage

// File: sv/crat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crat_front
// control point window and per-segment polynomial coefficients
// ----------------------------------------------------------------------------
module crat_front #(
   parameter int CoordWidth = crat_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [CoordWidth-1:0] req_point_x,
   input  logic signed [CoordWidth-1:0] req_point_y,
   input  logic signed [CoordWidth-1:0] req_point_z,
   input  logic                         req_new_curve,
   output logic                         job_valid,
   input  logic                         job_ready,
   output logic [12*(CoordWidth+4)-1:0] job_data
);

   localparam int CfW = CoordWidth + 4;

   logic [1:0] count_ff, count_in, count_eff;
   logic signed [CoordWidth-1:0] win_ff [3][3];
   logic signed [CoordWidth-1:0] pt [3];
   logic full, accept;

   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;

   assign count_eff = req_new_curve ? 2'd0 : count_ff;
   assign full      = (count_eff == 2'd3);
   assign req_ready = !full || job_ready;
   assign job_valid = req_valid && full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      count_in = count_ff;
      if (accept && !full) begin
         count_in = count_eff + 2'd1;
      end else if (accept) begin
         count_in = count_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int a = 0; a < 3; a++) begin
            if (full) begin
               win_ff[0][a] <= win_ff[1][a];
               win_ff[1][a] <= win_ff[2][a];
               win_ff[2][a] <= pt[a];
            end else begin
               win_ff[count_eff][a] <= pt[a];
            end
         end
      end
   end

   // a3 = -p1+3p2-3p3+p4, a2 = 2p1-5p2+4p3-p4, a1 = p3-p1, a0 = 2p2
   always_comb begin
      logic signed [CfW-1:0] e1, e2, e3, e4;
      job_data = '0;
      for (int a = 0; a < 3; a++) begin
         e1 = CfW'(win_ff[0][a]);
         e2 = CfW'(win_ff[1][a]);
         e3 = CfW'(win_ff[2][a]);
         e4 = CfW'(pt[a]);
         job_data[(a*4+3)*CfW +: CfW] = CfW'(-e1 + 3*e2 - 3*e3 + e4);
         job_data[(a*4+2)*CfW +: CfW] = CfW'(2*e1 - 5*e2 + 4*e3 - e4);
         job_data[(a*4+1)*CfW +: CfW] = e3 - e1;
         job_data[(a*4+0)*CfW +: CfW] = CfW'(2*e2);
      end
   end

endmodule

// File: sv/crat_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crat_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module crat_queue #(
   parameter int DataWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DataWidth-1:0] in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DataWidth-1:0] out_data
);

   localparam int Depth = crat_pkg::QUEUE_DEPTH;
   localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW    = $clog2(Depth + 1);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != CW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: sv/crat_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crat_back
// depth-first subdivision engine on one shared multiplier
// ----------------------------------------------------------------------------
module crat_back #(
   parameter int MaxDepth   = crat_pkg::MAX_DEPTH_DEFAULT,
   parameter int CoordWidth = crat_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      job_valid,
   output logic                                      job_ready,
   input  logic [12*(CoordWidth+4)-1:0]              job_data,
   input  logic [crat_pkg::CSR_WIDTH-1:0]            max_len_sq,
   input  logic [crat_pkg::DEPTH_LIMIT_WIDTH-1:0]    depth_limit,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [CoordWidth-1:0]              rsp_start_x,
   output logic signed [CoordWidth-1:0]              rsp_start_y,
   output logic signed [CoordWidth-1:0]              rsp_start_z,
   output logic signed [CoordWidth-1:0]              rsp_end_x,
   output logic signed [CoordWidth-1:0]              rsp_end_y,
   output logic signed [CoordWidth-1:0]              rsp_end_z,
   output logic                                      rsp_depth_capped,
   output logic                                      rsp_run_last
);

   localparam int W      = CoordWidth;
   localparam int CfW    = W + 4;
   localparam int NW0    = W + 6 + 3*MaxDepth;
   localparam int NW     = (NW0 > 2*W + 2) ? NW0 : 2*W + 2;
   localparam int KB     = (W + 1 > MaxDepth + 2) ? W + 1 : MaxDepth + 2;
   localparam int KW     = MaxDepth + 1;
   localparam int LW     = $clog2(MaxDepth + 1);
   localparam int SUMW   = 2*W + 3;
   localparam int SQF    = 2*(W - 2);
   localparam int SHS    = (SQF < crat_pkg::THR_FRAC) ? crat_pkg::THR_FRAC - SQF : 0;
   localparam int SHT    = (SQF >= crat_pkg::THR_FRAC) ? SQF - crat_pkg::THR_FRAC : 0;
   localparam int CMPA   = SUMW + SHS;
   localparam int CMPB   = crat_pkg::CSR_WIDTH + SHT;
   localparam int CMPW   = (CMPA > CMPB) ? CMPA : CMPB;
   localparam logic [KW-1:0] FULL = KW'(1) << MaxDepth;
   localparam logic signed [NW-1:0] CMAX_N = NW'((2**(W-1)) - 1);
   localparam logic signed [NW-1:0] CMIN_N = -CMAX_N - NW'(1);

   crat_pkg::back_state_type state_ff, state_in;

   logic signed [CfW-1:0] coef_ff [12];
   logic [KW-1:0] pos_ff, pos_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [1:0] axis_ff, axis_in, step_ff, step_in;
   logic which_ff, which_in;
   logic signed [NW-1:0] acc_ff, acc_in;
   logic signed [W-1:0] spt_ff [3];
   logic signed [W-1:0] ept_ff [3];
   logic [SUMW-1:0] sum_ff, sum_in;
   logic lng_ff, lng_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] os_ff [3];
   logic signed [W-1:0] oe_ff [3];
   logic capped_ff, last_ff;

   logic [LW-1:0] lim;
   logic [KW-1:0] w, k, npos;
   logic signed [NW-1:0] m_a;
   logic signed [KB-1:0] m_b;
   logic signed [NW+KB-1:0] prod;
   logic signed [NW-1:0] rnd, rsh, rsat;
   logic signed [W:0] d;
   logic signed [CfW-1:0] cf3, cf2, cf1, cf0;
   logic [CMPW-1:0] lhs, rhs;
   logic too_long, out_free, do_emit, last_leaf;
   logic [LW-1:0] nlvl;
   logic [KW-1:0] tmp;

   assign job_ready = (state_ff == crat_pkg::ST_IDLE);
   assign lim = (depth_limit > crat_pkg::DEPTH_LIMIT_WIDTH'(MaxDepth)) ? LW'(MaxDepth)
                                                                      : depth_limit[LW-1:0];
   assign w         = KW'(1) << (MaxDepth - int'(lvl_ff));
   assign npos      = pos_ff + w;
   assign k         = which_ff ? npos : pos_ff;
   assign last_leaf = (npos >= FULL);

   assign cf3 = coef_ff[{axis_ff, 2'd3}];
   assign cf2 = coef_ff[{axis_ff, 2'd2}];
   assign cf1 = coef_ff[{axis_ff, 2'd1}];
   assign cf0 = coef_ff[{axis_ff, 2'd0}];

   assign d = (W+1)'(ept_ff[axis_ff]) - (W+1)'(spt_ff[axis_ff]);

   // shared multiplier: horner steps of the cubic or one chord square
   always_comb begin
      if (state_ff == crat_pkg::ST_CHORD) begin
         m_a = NW'(d);
         m_b = KB'(d);
      end else begin
         m_a = (step_ff == 2'd0) ? NW'(cf3) : acc_ff;
         m_b = KB'({1'b0, k});
      end
   end
   assign prod = m_a * m_b;

   // round half up, then saturate
   assign rnd = acc_ff + (NW'(1) <<< (3*MaxDepth));
   assign rsh = rnd >>> (3*MaxDepth + 1);
   assign rsat = (rsh > CMAX_N) ? CMAX_N : ((rsh < CMIN_N) ? CMIN_N : rsh);

   assign lhs = CMPW'(sum_ff) << SHS;
   assign rhs = CMPW'(max_len_sq) << SHT;
   assign too_long = (lhs > rhs);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign do_emit  = (state_ff == crat_pkg::ST_EMIT) && out_free;

   // climb back up while the new position is a left edge
   always_comb begin
      nlvl = lvl_ff;
      for (int i = 0; i < MaxDepth; i++) begin
         tmp = npos >> (MaxDepth - int'(nlvl));
         if (nlvl != '0 && !tmp[0]) begin
            nlvl = nlvl - LW'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      lvl_in       = lvl_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      which_in     = which_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      lng_in       = lng_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         crat_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = crat_pkg::ST_EVAL;
               pos_in   = '0;
               lvl_in   = '0;
               axis_in  = 2'd0;
               step_in  = 2'd0;
               which_in = 1'b0;
            end
         end
         crat_pkg::ST_EVAL: begin
            step_in = step_ff + 2'd1;
            unique case (step_ff)
               2'd0: acc_in = prod[NW-1:0] + (NW'(cf2) <<< MaxDepth);
               2'd1: acc_in = prod[NW-1:0] + (NW'(cf1) <<< (2*MaxDepth));
               2'd2: acc_in = prod[NW-1:0] + (NW'(cf0) <<< (3*MaxDepth));
               default: begin
                  step_in = 2'd0;
                  if (axis_ff == 2'd2) begin
                     axis_in = 2'd0;
                     if (which_ff) begin
                        state_in = crat_pkg::ST_CHORD;
                     end else begin
                        which_in = 1'b1;
                     end
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
            endcase
         end
         crat_pkg::ST_CHORD: begin
            sum_in = ((axis_ff == 2'd0) ? '0 : sum_ff) + prod[SUMW-1:0];
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = crat_pkg::ST_DECIDE;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         crat_pkg::ST_DECIDE: begin
            lng_in   = too_long;
            which_in = 1'b0;
            if (too_long && lvl_ff < lim) begin
               lvl_in   = lvl_ff + LW'(1);
               state_in = crat_pkg::ST_EVAL;
            end else begin
               state_in = crat_pkg::ST_EMIT;
            end
         end
         crat_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pos_in       = npos;
               lvl_in       = nlvl;
               state_in     = last_leaf ? crat_pkg::ST_IDLE : crat_pkg::ST_EVAL;
            end
         end
         default: state_in = crat_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crat_pkg::ST_IDLE;
         pos_ff       <= '0;
         lvl_ff       <= '0;
         axis_ff      <= 2'd0;
         step_ff      <= 2'd0;
         which_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         lvl_ff       <= lvl_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         which_ff     <= which_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sum_ff <= sum_in;
      lng_ff <= lng_in;
      if (job_valid && job_ready) begin
         for (int i = 0; i < 12; i++) begin
            coef_ff[i] <= job_data[i*CfW +: CfW];
         end
      end
      if (state_ff == crat_pkg::ST_EVAL && step_ff == 2'd3) begin
         if (which_ff) begin
            ept_ff[axis_ff] <= rsat[W-1:0];
         end else begin
            spt_ff[axis_ff] <= rsat[W-1:0];
         end
      end
      if (do_emit) begin
         os_ff     <= spt_ff;
         oe_ff     <= ept_ff;
         capped_ff <= lng_ff;
         last_ff   <= last_leaf;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_start_x      = os_ff[0];
   assign rsp_start_y      = os_ff[1];
   assign rsp_start_z      = os_ff[2];
   assign rsp_end_x        = oe_ff[0];
   assign rsp_end_y        = oe_ff[1];
   assign rsp_end_z        = oe_ff[2];
   assign rsp_depth_capped = capped_ff;
   assign rsp_run_last     = last_ff;

endmodule

// File: sv/catmull_rom_adaptive_tessellator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_adaptive_tessellator
// adaptive catmull-rom subdivision of a stream of 3-d control points
// ----------------------------------------------------------------------------
// usage
//  - req_ channel: one control point per transfer; req_new_curve empties the
//    point window before the point is taken
//  - rsp_ channel: line segments with both end points; rsp_run_last marks the
//    final segment caused by one point, rsp_depth_capped a segment emitted at
//    the depth limit while still longer than the threshold
//  - csr_ port: write-only, max_len_sq (index 0) and depth_limit (index 1)
// timing
//  - a point that only fills the window gives no result
//  - a point closing a segment: each visited interval runs on the single shared
//    multiplier (horner steps for both end points on each of the three axes,
//    the chord squares, a compare), and each emitted leaf passes the emit state
//  - a two-entry job queue lets the front keep taking window points while the
//    back end works
// reset: window empty, engine idle, registers back to their defaults
// a stalled receiver holds the output register; the engine then waits
// ----------------------------------------------------------------------------
module catmull_rom_adaptive_tessellator #(
   parameter int MaxDepth   = crat_pkg::MAX_DEPTH_DEFAULT,
   parameter int CoordWidth = crat_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [CoordWidth-1:0]          req_point_x,
   input  logic signed [CoordWidth-1:0]          req_point_y,
   input  logic signed [CoordWidth-1:0]          req_point_z,
   input  logic                                  req_new_curve,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [CoordWidth-1:0]          rsp_start_x,
   output logic signed [CoordWidth-1:0]          rsp_start_y,
   output logic signed [CoordWidth-1:0]          rsp_start_z,
   output logic signed [CoordWidth-1:0]          rsp_end_x,
   output logic signed [CoordWidth-1:0]          rsp_end_y,
   output logic signed [CoordWidth-1:0]          rsp_end_z,
   output logic                                  rsp_depth_capped,
   output logic                                  rsp_run_last,
   input  logic                                  csr_we,
   input  logic [crat_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [crat_pkg::CSR_WIDTH-1:0]        csr_wdata
);

   // four coefficients per axis, three axes
   localparam int JobWidth = 12 * (CoordWidth + 4);

   logic [crat_pkg::CSR_WIDTH-1:0]         max_len_sq_ff;
   logic [crat_pkg::DEPTH_LIMIT_WIDTH-1:0] depth_limit_ff;

   logic                job_valid, job_ready;
   logic [JobWidth-1:0] job_data;
   logic                eng_valid, eng_ready;
   logic [JobWidth-1:0] eng_data;

   // configuration registers, to be written only while idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_sq_ff  <= crat_pkg::MAX_LEN_SQ_RESET;
         depth_limit_ff <= crat_pkg::DEPTH_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (crat_pkg::csr_index_type'(csr_index))
            crat_pkg::CSR_MAX_LEN_SQ:  max_len_sq_ff  <= csr_wdata;
            crat_pkg::CSR_DEPTH_LIMIT:
               depth_limit_ff <= csr_wdata[crat_pkg::DEPTH_LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // front: window and coefficients
   crat_front #(
      .CoordWidth (CoordWidth)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_new_curve (req_new_curve),
      .job_valid     (job_valid),
      .job_ready     (job_ready),
      .job_data      (job_data)
   );

   // queue decoupling front and back
   crat_queue #(
      .DataWidth (JobWidth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_ready  (job_ready),
      .in_data   (job_data),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out_data  (eng_data)
   );

   // back: subdivision and output register
   crat_back #(
      .MaxDepth   (MaxDepth),
      .CoordWidth (CoordWidth)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (eng_valid),
      .job_ready        (eng_ready),
      .job_data         (eng_data),
      .max_len_sq       (max_len_sq_ff),
      .depth_limit      (depth_limit_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_start_z      (rsp_start_z),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_end_z        (rsp_end_z),
      .rsp_depth_capped (rsp_depth_capped),
      .rsp_run_last     (rsp_run_last)
   );

`ifndef SYNTH
   // a point transfer that closes a segment always finds room in the queue
   a_job_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && job_valid) |-> job_ready)
      else $error("segment job taken without queue room");

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a point that only fills the window never enqueues a job
   a_fill_no_job: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !job_valid) |=> !$rose(eng_valid) || $past(job_valid))
      else $error("queue filled by a window-only point");
`endif

endmodule

// File: tb/catmull_rom_adaptive_tessellator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_adaptive_tessellator_checker
// watches the point, segment and csr channels, predicts the line segments and
// compares every segment transfer, all fields at once, against the oldest prediction
// ----------------------------------------------------------------------------
module catmull_rom_adaptive_tessellator_checker #(
   parameter int MaxDepth   = crat_pkg::MAX_DEPTH_DEFAULT,
   parameter int CoordWidth = crat_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [CoordWidth-1:0]         req_point_x,
   input  logic signed [CoordWidth-1:0]         req_point_y,
   input  logic signed [CoordWidth-1:0]         req_point_z,
   input  logic                                 req_new_curve,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [CoordWidth-1:0]         rsp_start_x,
   input  logic signed [CoordWidth-1:0]         rsp_start_y,
   input  logic signed [CoordWidth-1:0]         rsp_start_z,
   input  logic signed [CoordWidth-1:0]         rsp_end_x,
   input  logic signed [CoordWidth-1:0]         rsp_end_y,
   input  logic signed [CoordWidth-1:0]         rsp_end_z,
   input  logic                                 rsp_depth_capped,
   input  logic                                 rsp_run_last,
   input  logic                                 csr_we,
   input  logic [crat_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [crat_pkg::CSR_WIDTH-1:0]       csr_wdata,
   output int                                   fail_count,
   output int                                   segments_pending
);

   localparam longint CoordMax = (64'sd1 <<< (CoordWidth - 1)) - 1;
   localparam longint CoordMin = -(64'sd1 <<< (CoordWidth - 1));
   localparam int     SqFrac   = 2 * (CoordWidth - 2);

   typedef struct packed {
      logic signed [CoordWidth-1:0] sx, sy, sz, ex, ey, ez;
      logic                         capped;
      logic                         last;
   } segment_type;

   segment_type    segment_queue[$];
   logic [crat_pkg::CSR_WIDTH-1:0]         thr_sq;
   logic [crat_pkg::DEPTH_LIMIT_WIDTH-1:0] depth_lim;
   longint         window_pts[3][3];
   int             held;

   function automatic longint curve_axis(longint p1, longint p2, longint p3, longint p4,
                                         longint k);
      longint c3, c2, c1, c0, u, n, r;
      c3 = -p1 + 3 * p2 - 3 * p3 + p4;
      c2 = 2 * p1 - 5 * p2 + 4 * p3 - p4;
      c1 = p3 - p1;
      c0 = 2 * p2;
      u  = 64'sd1 <<< MaxDepth;
      n  = c3 * k * k * k + c2 * k * k * u + c1 * k * u * u + c0 * u * u * u;
      // arithmetic shift floors, so adding half first rounds half up
      r  = (n + (64'sd1 <<< (3 * MaxDepth))) >>> (3 * MaxDepth + 1);
      if (r > CoordMax) r = CoordMax;
      if (r < CoordMin) r = CoordMin;
      return r;
   endfunction

   function automatic void tessellate(longint q[4][3]);
      int          lim, lvl, cnt;
      int          pos, w;
      longint      s[3], e[3], d;
      logic [63:0] sum, lhs, rhs;
      logic        lng;
      segment_type seg;
      lim = (depth_lim > MaxDepth) ? MaxDepth : int'(depth_lim);
      pos = 0; lvl = 0; cnt = 0;
      while (cnt < (1 << MaxDepth)) begin
         w = 1 << (MaxDepth - lvl);
         sum = 0;
         for (int a = 0; a < 3; a++) begin
            s[a] = curve_axis(q[0][a], q[1][a], q[2][a], q[3][a], pos);
            e[a] = curve_axis(q[0][a], q[1][a], q[2][a], q[3][a], pos + w);
            d = e[a] - s[a];
            sum += 64'(d * d);
         end
         if (SqFrac >= crat_pkg::THR_FRAC) begin
            lhs = sum;
            rhs = 64'(thr_sq) << (SqFrac - crat_pkg::THR_FRAC);
         end else begin
            lhs = sum << (crat_pkg::THR_FRAC - SqFrac);
            rhs = 64'(thr_sq);
         end
         lng = lhs > rhs;
         if (lng && lvl < lim) begin
            lvl++;
            continue;
         end
         seg.sx = CoordWidth'(s[0]); seg.sy = CoordWidth'(s[1]); seg.sz = CoordWidth'(s[2]);
         seg.ex = CoordWidth'(e[0]); seg.ey = CoordWidth'(e[1]); seg.ez = CoordWidth'(e[2]);
         seg.capped = lng;
         seg.last   = 1'b0;
         segment_queue.insert(segment_queue.size(), seg);
         cnt++;
         pos += w;
         if (pos >= (1 << MaxDepth)) break;
         while (lvl > 0 && ((pos >> (MaxDepth - lvl)) & 1) == 0) lvl--;
      end
      segment_queue[segment_queue.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      longint pt[3];
      longint q[4][3];
      segment_type want, got;
      if (reset) begin
         thr_sq    <= crat_pkg::MAX_LEN_SQ_RESET;
         depth_lim <= crat_pkg::DEPTH_LIMIT_RESET;
         held      = 0;
         fail_count <= 0;
         segment_queue.delete();
      end else begin
         if (csr_we) begin
            case (crat_pkg::csr_index_type'(csr_index))
               crat_pkg::CSR_MAX_LEN_SQ:  thr_sq    <= csr_wdata;
               crat_pkg::CSR_DEPTH_LIMIT:
                  depth_lim <= csr_wdata[crat_pkg::DEPTH_LIMIT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pt[0] = longint'(req_point_x);
            pt[1] = longint'(req_point_y);
            pt[2] = longint'(req_point_z);
            if (req_new_curve) held = 0;
            if (held >= 3) begin
               for (int i = 0; i < 3; i++)
                  for (int a = 0; a < 3; a++) q[i][a] = window_pts[i][a];
               for (int a = 0; a < 3; a++) q[3][a] = pt[a];
               tessellate(q);
               for (int a = 0; a < 3; a++) begin
                  window_pts[0][a] = window_pts[1][a];
                  window_pts[1][a] = window_pts[2][a];
                  window_pts[2][a] = pt[a];
               end
            end else begin
               for (int a = 0; a < 3; a++) window_pts[held][a] = pt[a];
               held++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_start_x, rsp_start_y, rsp_start_z, rsp_end_x, rsp_end_y,
                    rsp_end_z, rsp_depth_capped, rsp_run_last};
            if (segment_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected segment %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = segment_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("segment mismatch: expected %p, got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      segments_pending <= segment_queue.size();
   end

endmodule

// File: tb/catmull_rom_adaptive_tessellator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_adaptive_tessellator_tb
// drives control point streams through the tessellator under several
// threshold and depth settings, with bursty sender and stalling receiver;
// the checker predicts and compares every segment
// ----------------------------------------------------------------------------
module catmull_rom_adaptive_tessellator_tb;

   localparam int CsrW = crat_pkg::CSR_WIDTH;

   logic clock, reset;
   logic req_valid, req_ready, req_new_curve;
   logic signed [15:0] req_point_x, req_point_y, req_point_z;
   logic rsp_valid, rsp_ready;
   logic signed [15:0] rsp_start_x, rsp_start_y, rsp_start_z;
   logic signed [15:0] rsp_end_x, rsp_end_y, rsp_end_z;
   logic rsp_depth_capped, rsp_run_last;
   logic csr_we;
   logic [crat_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CsrW-1:0] csr_wdata;
   int   fail_count, segments_pending;
   int   burst_left, gap_left;

   catmull_rom_adaptive_tessellator dut (.*);

   catmull_rom_adaptive_tessellator_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stall pattern: stretches of random length, each one at random calm or choppy
   initial begin
      int phase_len;
      bit choppy;
      rsp_ready = 1'b0;
      forever begin
         choppy = 1'($urandom_range(0, 1));
         phase_len = $urandom_range(20, 300);
         repeat (phase_len) begin
            @(posedge clock);
            rsp_ready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
         end
      end
   end

   // one point transfer; sender idles in random gaps between bursts
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic nc);
      if (burst_left == 0) begin
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            repeat (gap_left) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_point_x <= x; req_point_y <= y; req_point_z <= z;
      req_new_curve <= nc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   // wait for all predicted segments, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (segments_pending != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
   endtask

   task automatic csr_write(crat_pkg::csr_index_type idx, logic [CsrW-1:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // a curve: new_curve on the first point, each coordinate drawn at random within +-spread
   task automatic random_curve(int npts, int spread);
      logic signed [15:0] x, y, z;
      for (int i = 0; i < npts; i++) begin
         x = 16'($urandom_range(0, 2 * spread) - spread);
         y = 16'($urandom_range(0, 2 * spread) - spread);
         z = 16'($urandom_range(0, 2 * spread) - spread);
         send_point(x, y, z, i == 0);
      end
   endtask

   initial begin
      logic [CsrW-1:0] thr;
      req_valid = 1'b0; req_new_curve = 1'b0;
      req_point_x = '0; req_point_y = '0; req_point_z = '0;
      csr_we = 1'b0; csr_index = crat_pkg::CSR_MAX_LEN_SQ; csr_wdata = '0;
      burst_left = 0; gap_left = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default settings, extremes and overshoot
      send_point(16'sh8000, 16'sh7fff, 16'sh0000, 1'b1);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
      send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
      send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      // new curve mid-stream restarts the window
      send_point(16'sh0100, 16'sh0200, -16'sh0100, 1'b1);
      send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      send_point(16'sh5555, -16'sh5556, 16'sh2aaa, 1'b0);
      drain();

      // zero depth: whole interval as one segment, marked if long
      csr_write(crat_pkg::CSR_DEPTH_LIMIT, '0);
      csr_write(crat_pkg::CSR_MAX_LEN_SQ, '0);
      random_curve(6, 32768 - 1);
      drain();
      // depth limit above the maximum saturates; largest threshold
      csr_write(crat_pkg::CSR_DEPTH_LIMIT, CsrW'(7));
      csr_write(crat_pkg::CSR_MAX_LEN_SQ, {CsrW{1'b1}});
      random_curve(6, 32767);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(crat_pkg::CSR_DEPTH_LIMIT, CsrW'($urandom_range(0, 7)));
         case ($urandom_range(0, 2))
            0: thr = CsrW'($urandom_range(0, 50000));
            1: thr = crat_pkg::MAX_LEN_SQ_RESET;
            default: thr = {2'($urandom_range(0, 3)), $urandom()};
         endcase
         csr_write(crat_pkg::CSR_MAX_LEN_SQ, thr);
         for (int c = 0; c < 4; c++)
            random_curve($urandom_range(4, 10),
                         ($urandom_range(0, 4) == 0) ? 32767 : $urandom_range(64, 8000));
         // single stray points with random flags
         send_point(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    1'($urandom_range(0, 1)));
         drain();
      end
      csr_write(crat_pkg::CSR_DEPTH_LIMIT, CsrW'(crat_pkg::DEPTH_LIMIT_RESET));
      csr_write(crat_pkg::CSR_MAX_LEN_SQ, crat_pkg::MAX_LEN_SQ_RESET);
      random_curve(8, 3000);
      drain();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
